// ===== design/fm0_pkg.sv =====
// Shared types and constants for the FM0 backscatter encoder.
// Used by fm0_core and fm0_backscatter_encoder; depends on nothing else.

package fm0_pkg;

   // Data store geometry.
   localparam int unsigned DATA_BYTES = 32;
   localparam int unsigned BYTE_AW    = $clog2(DATA_BYTES);

   // Field widths.
   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CNT_W   = 9;
   localparam int unsigned PIDX_W  = 5;
   localparam int unsigned PRE_W   = 18;

   // Preamble length and the bit whose boundary toggle is suppressed.
   localparam logic [PIDX_W-1:0] PRE_BITS   = 5'd18;
   localparam logic [PIDX_W-1:0] VIOL_INDEX = 5'd16;
   localparam logic [PIDX_W-1:0] PRE_LAST   = 5'd17;

   // Operation codes carried in the request tuser.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // One request transaction.
   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   byte_address;
      logic [BYTE_W-1:0]   byte_value;
      logic [CNT_W-1:0]    bit_count;
   } item_type;

   // One response transaction.
   typedef struct packed {
      logic stop_request;
      logic frame_finished;
      logic line_level;
   } result_type;

endpackage

// ===== design/fm0_core.sv =====
// Encoder state, data store and preamble register of the FM0 encoder.
// Computes the next state and the response of each accepted request combinationally.
// Depends on fm0_pkg.

module fm0_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_accept,
   input  fm0_pkg::item_type             item,
   input  logic                          csr_write,
   input  logic [fm0_pkg::PRE_W-1:0]     csr_value,
   output fm0_pkg::result_type           result
);

   // Encoder state.
   logic                          hp_ff, hp_in;
   logic [fm0_pkg::PIDX_W-1:0]    pidx_ff, pidx_in;
   logic                          pdone_ff, pdone_in;
   logic                          cur_ff, cur_in;
   logic [fm0_pkg::CNT_W-1:0]     dbi_ff, dbi_in;
   logic [fm0_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic                          fin_ff, fin_in;
   logic                          level_ff, level_in;
   logic [fm0_pkg::PRE_W-1:0]     pattern_ff;
   logic                          stop;

   // Data store, no reset; the user must write every entry that a frame reads, the core does not enforce it.
   logic [fm0_pkg::BYTE_W-1:0]    store_ff [fm0_pkg::DATA_BYTES];

   // Bit fetches. The byte index wraps modulo the store depth.
   logic [fm0_pkg::BYTE_AW-1:0]   byte_pos;
   logic [2:0]                    bit_sel;
   logic                          data_bit;
   logic [fm0_pkg::PIDX_W-1:0]    pre_pos;
   logic                          pre_bit;

   assign byte_pos = dbi_ff[fm0_pkg::BYTE_AW+2:3];
   assign bit_sel  = 3'd7 - dbi_ff[2:0];
   assign data_bit = store_ff[byte_pos][bit_sel];
   assign pre_pos  = fm0_pkg::PRE_LAST - pidx_ff;
   assign pre_bit  = (pidx_ff < fm0_pkg::PRE_BITS) ? pattern_ff[pre_pos] : 1'b0;

   // Next state for the accepted request.
   always_comb begin
      hp_in    = hp_ff;
      pidx_in  = pidx_ff;
      pdone_in = pdone_ff;
      cur_in   = cur_ff;
      dbi_in   = dbi_ff;
      rem_in   = rem_ff;
      fin_in   = fin_ff;
      level_in = level_ff;
      stop     = 1'b0;
      if (item_accept) begin
         case (item.op)
            fm0_pkg::OP_START: begin
               hp_in    = 1'b0;
               pidx_in  = '0;
               pdone_in = 1'b0;
               dbi_in   = '0;
               fin_in   = 1'b0;
               rem_in   = item.bit_count;
            end
            fm0_pkg::OP_TICK: begin
               if (!pdone_ff) begin
                  // Preamble: boundary toggle except at the violation bit.
                  if (hp_ff) begin
                     if (!cur_ff) level_in = ~level_ff;
                  end else begin
                     if (pidx_ff != fm0_pkg::VIOL_INDEX) level_in = ~level_ff;
                     cur_in  = pre_bit;
                     pidx_in = pidx_ff + 5'd1;
                  end
                  if (pidx_in >= fm0_pkg::PRE_BITS) pdone_in = 1'b1;
               end else if (rem_ff != '0) begin
                  // Data bits, MSB of each byte first.
                  if (hp_ff) begin
                     if (!cur_ff) level_in = ~level_ff;
                  end else begin
                     level_in = ~level_ff;
                     cur_in   = data_bit;
                     dbi_in   = dbi_ff + 9'd1;
                     rem_in   = rem_ff - 9'd1;
                  end
               end else if (!fin_ff) begin
                  if (!hp_ff) fin_in = 1'b1;
               end else begin
                  stop = 1'b1;
               end
               hp_in = ~hp_ff;
            end
            default: begin
               // Writes touch only the store; the reserved code does nothing.
            end
         endcase
      end
   end

   assign result.line_level     = level_in;
   assign result.frame_finished = fin_in;
   assign result.stop_request   = stop;

   // State registers and the preamble register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff      <= 1'b0;
         pidx_ff    <= '0;
         pdone_ff   <= 1'b0;
         cur_ff     <= 1'b0;
         dbi_ff     <= '0;
         rem_ff     <= '0;
         fin_ff     <= 1'b0;
         level_ff   <= 1'b0;
         pattern_ff <= '0;
      end else begin
         hp_ff    <= hp_in;
         pidx_ff  <= pidx_in;
         pdone_ff <= pdone_in;
         cur_ff   <= cur_in;
         dbi_ff   <= dbi_in;
         rem_ff   <= rem_in;
         fin_ff   <= fin_in;
         level_ff <= level_in;
         if (csr_write) pattern_ff <= csr_value;
      end
   end

   // Store write. Every 5-bit address lies inside the 32-byte store.
   always_ff @(posedge clock) begin
      if (item_accept && item.op == fm0_pkg::OP_WRITE) begin
         store_ff[item.byte_address[fm0_pkg::BYTE_AW-1:0]] <= item.byte_value;
      end
   end

   // A stop request is only raised once the frame is finished.
   a_stop_needs_fin: assert property (@(posedge clock) disable iff (reset)
      stop |-> fin_ff && fin_in)
      else $error("stop request without finished frame");

   // Once the preamble is done, its index rests at the preamble length.
   a_pdone_index: assert property (@(posedge clock) disable iff (reset)
      pdone_ff |-> pidx_ff == fm0_pkg::PRE_BITS)
      else $error("preamble done with wrong index");

   // A start restarts the half-bit phase and clears the finished flag.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      item_accept && item.op == fm0_pkg::OP_START |=> !hp_ff && !fin_ff && !pdone_ff)
      else $error("start did not clear the frame state");

   // The line only moves on an accepted tick.
   a_level_on_tick: assert property (@(posedge clock) disable iff (reset)
      !(item_accept && item.op == fm0_pkg::OP_TICK) |=> $stable(level_ff))
      else $error("line level changed without a tick");

endmodule

// ===== design/fm0_backscatter_encoder.sv =====
// Top level of the FM0 backscatter encoder: stream handshakes and the response register.
// Depends on fm0_pkg and fm0_core.
//
//  Channel | Direction | Ports                                   | Contents
//  req     | in        | req_tvalid req_tready req_tdata req_tuser | one operation
//  rsp     | out       | rsp_tvalid rsp_tready rsp_tdata           | line state after it
//  csr     | in        | csr_valid csr_ready csr_data              | preamble pattern
//
// The encoder state and the response register both update at the accepting edge, so
// the response is in the output register in the cycle after the request is accepted.
// One request is accepted every cycle while the response register is empty or drained.
// A stalled response holds the output register and stalls only the request side.
// Reset clears the encoder state and the preamble pattern; the data store keeps no reset.
// The csr channel is always ready.

module fm0_backscatter_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // byte_address[4:0], byte_value[12:5], bit_count[21:13], zeros
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // line_level[0], frame_finished[1], stop_request[2], zeros
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [17:0] csr_data
);

   logic                 req_accept;
   fm0_pkg::item_type    item;
   fm0_pkg::result_type  result;
   logic                 rsp_valid_ff;
   fm0_pkg::result_type  rsp_data_ff;

   // Unpack the request transaction.
   assign item.op           = fm0_pkg::op_type'(req_tuser);
   assign item.byte_address = req_tdata[4:0];
   assign item.byte_value   = req_tdata[12:5];
   assign item.bit_count    = req_tdata[21:13];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   fm0_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_accept),
      .item        (item),
      .csr_write   (csr_valid),
      .csr_value   (csr_data),
      .result      (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_data_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.stop_request, rsp_data_ff.frame_finished,
                        rsp_data_ff.line_level};

endmodule

// ===== tb/fm0_checker.sv =====
// Scoreboard for the FM0 backscatter encoder: follows the request, response and csr channels,
// predicts each response from its own copy of the encoder state and compares field by field.
// Depends on fm0_pkg.
`timescale 1ns / 100ps

module fm0_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,  // byte_address[4:0], byte_value[12:5], bit_count[21:13], zeros
   input  logic [1:0]  req_tuser,  // operation[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,  // line_level[0], frame_finished[1], stop_request[2], zeros
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [17:0] csr_data,
   output int          error_count,
   output int          pending_count,
   output int          response_count
);

   // Predicted encoder state.
   logic [fm0_pkg::PRE_W-1:0]  preamble_bits;
   logic                       odd_half;
   logic [fm0_pkg::PIDX_W-1:0] preamble_pos;
   logic                       preamble_sent;
   logic                       symbol_bit;
   logic [fm0_pkg::CNT_W-1:0]  data_pos;
   logic [fm0_pkg::CNT_W-1:0]  bits_left;
   logic                       frame_done;
   logic                       line;
   logic [fm0_pkg::BYTE_W-1:0] byte_store [fm0_pkg::DATA_BYTES];

   // Responses predicted but not yet seen, oldest first.
   fm0_pkg::result_type        line_state_q [$];

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      error_count++;
      $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   // One half-bit period of the FM0 coder; returns whether the timer should stop.
   task automatic advance_half_bit(output logic stop_now);
      stop_now = 1'b0;
      if (!preamble_sent) begin
         if (odd_half) begin
            if (!symbol_bit) line = ~line;
         end else begin
            // The boundary toggle before the violation bit is left out.
            if (preamble_pos != fm0_pkg::VIOL_INDEX) line = ~line;
            symbol_bit = (preamble_pos < fm0_pkg::PRE_BITS)
                         ? preamble_bits[fm0_pkg::PRE_LAST - preamble_pos] : 1'b0;
            preamble_pos = preamble_pos + 1'b1;
         end
         if (preamble_pos >= fm0_pkg::PRE_BITS) preamble_sent = 1'b1;
      end else if (bits_left != '0) begin
         if (odd_half) begin
            if (!symbol_bit) line = ~line;
         end else begin
            line = ~line;
            symbol_bit = byte_store[data_pos[8:3] % fm0_pkg::DATA_BYTES][3'd7 - data_pos[2:0]];
            data_pos  = data_pos + 1'b1;
            bits_left = bits_left - 1'b1;
         end
      end else if (!frame_done) begin
         // The dummy bit closes on an even half.
         if (!odd_half) frame_done = 1'b1;
      end else begin
         stop_now = 1'b1;
      end
      odd_half = ~odd_half;
   endtask

   always @(posedge clock) begin
      fm0_pkg::result_type want;
      logic                stop_now;
      fm0_pkg::op_type     op;
      if (reset) begin
         preamble_bits = '0;
         odd_half      = 1'b0;
         preamble_pos  = '0;
         preamble_sent = 1'b0;
         symbol_bit    = 1'b0;
         data_pos      = '0;
         bits_left     = '0;
         frame_done    = 1'b0;
         line          = 1'b0;
         line_state_q.delete();
      end else begin
         // Compare a response transaction with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            response_count++;
            if (line_state_q.size() == 0) begin
               report_mismatch("response with nothing outstanding", 8'h00, rsp_tdata);
            end else begin
               want = line_state_q.pop_front();
               if (rsp_tdata[0] !== want.line_level)
                  report_mismatch("line_level", {7'd0, want.line_level},
                                  {7'd0, rsp_tdata[0]});
               if (rsp_tdata[1] !== want.frame_finished)
                  report_mismatch("frame_finished", {7'd0, want.frame_finished},
                                  {7'd0, rsp_tdata[1]});
               if (rsp_tdata[2] !== want.stop_request)
                  report_mismatch("stop_request", {7'd0, want.stop_request},
                                  {7'd0, rsp_tdata[2]});
               if (rsp_tdata[7:3] !== 5'd0)
                  report_mismatch("response padding", 8'h00, {3'd0, rsp_tdata[7:3]});
            end
         end

         if (csr_valid && csr_ready) preamble_bits = csr_data;

         // Apply an accepted request transaction and record the state it leaves.
         if (req_tvalid && req_tready) begin
            stop_now = 1'b0;
            op = fm0_pkg::op_type'(req_tuser);
            case (op)
               fm0_pkg::OP_WRITE: begin
                  if (req_tdata[4:0] < fm0_pkg::DATA_BYTES)
                     byte_store[req_tdata[4:0]] = req_tdata[12:5];
               end
               fm0_pkg::OP_START: begin
                  odd_half      = 1'b0;
                  preamble_pos  = '0;
                  preamble_sent = 1'b0;
                  data_pos      = '0;
                  frame_done    = 1'b0;
                  bits_left     = req_tdata[21:13];
               end
               fm0_pkg::OP_TICK: advance_half_bit(stop_now);
               default: ;
            endcase
            want.line_level     = line;
            want.frame_finished = frame_done;
            want.stop_request   = stop_now;
            line_state_q.push_back(want);
         end
      end
      pending_count <= line_state_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the FM0 backscatter encoder testbench: clock, reset, request and csr stimulus,
// response back-pressure and the verdict. Depends on fm0_pkg, fm0_backscatter_encoder, fm0_checker.
`timescale 1ns / 100ps

module tb;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int         PHASES      = 4;
   localparam int         PHASE_ITEMS = 125;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // byte_address[4:0], byte_value[12:5], bit_count[21:13], zeros
   logic [1:0]  req_tuser  = '0;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // line_level[0], frame_finished[1], stop_request[2], zeros
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [17:0] csr_data   = '0;

   logic        quiet_req  = 1'b0;
   logic        quiet_rsp  = 1'b0;
   bit          byte_written [fm0_pkg::DATA_BYTES];
   int          sent_total;
   int          frame_total;
   int          setting_total;
   int          error_count;
   int          pending_count;
   int          response_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   fm0_backscatter_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   fm0_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .response_count (response_count)
   );

   function automatic int pick_gap(input logic quiet);
      return quiet ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic [fm0_pkg::CNT_W-1:0] rand_count();
      return fm0_pkg::CNT_W'($urandom_range(0, 256));
   endfunction

   // Offer one request transaction and hold it until it is taken.
   task automatic send_item(input logic [1:0] op, input logic [fm0_pkg::ADDR_W-1:0] addr,
                            input logic [fm0_pkg::BYTE_W-1:0] value,
                            input logic [fm0_pkg::CNT_W-1:0] count);
      int gap;
      gap = pick_gap(quiet_req);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, count, value, addr};
      do @(posedge clock); while (!req_tready);
      if (op == fm0_pkg::OP_WRITE) byte_written[addr] = 1'b1;
      sent_total++;
   endtask

   // Stop offering requests and wait until every response has been taken.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_preamble(input logic [17:0] pattern);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= pattern;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      setting_total++;
   endtask

   // Stray transaction in the middle of a frame: reserved code or a byte rewrite.
   task automatic send_noise();
      if ($urandom_range(0, 1) == 0)
         send_item(OP_RESERVED, fm0_pkg::ADDR_W'($urandom), fm0_pkg::BYTE_W'($urandom),
                   rand_count());
      else
         send_item(fm0_pkg::OP_WRITE, fm0_pkg::ADDR_W'($urandom), fm0_pkg::BYTE_W'($urandom),
                   rand_count());
   endtask

   // Load the payload, start a frame and tick it through, optionally cut short.
   task automatic run_frame(input int count, input bit whole, input bit hold_mid);
      int needed;
      int ticks;
      needed = (count + 7) / 8;
      // Every byte the frame will read must hold a written value.
      for (int b = 0; b < needed; b++)
         if (!byte_written[b] || $urandom_range(0, 2) == 0)
            send_item(fm0_pkg::OP_WRITE, fm0_pkg::ADDR_W'(b), fm0_pkg::BYTE_W'($urandom),
                      rand_count());
      send_item(fm0_pkg::OP_START, fm0_pkg::ADDR_W'($urandom), fm0_pkg::BYTE_W'($urandom),
                fm0_pkg::CNT_W'(count));
      // Preamble, data, the closing half and a few stop requests.
      ticks = 2 * fm0_pkg::PRE_W + 2 * count + 1 + $urandom_range(0, 6);
      // A cut frame ends before its full tick count; a long one stops within the preamble or the first data bits.
      if (!whole) ticks = $urandom_range(1, (ticks > 120) ? 120 : ticks - 1);
      for (int t = 0; t < ticks; t++) begin
         if (hold_mid && t == 20) wait_idle();
         if ($urandom_range(0, 15) == 0) send_noise();
         send_item(fm0_pkg::OP_TICK, fm0_pkg::ADDR_W'($urandom), fm0_pkg::BYTE_W'($urandom),
                   rand_count());
      end
      frame_total++;
   endtask

   // Response side: a fresh stall before each response transaction.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap(quiet_rsp);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int          base;
      int          count;
      bit          big;
      bit          whole;
      bit          first;
      logic [17:0] pattern;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: all-ones preamble, field extremes, every operation.
      write_preamble(18'h3FFFF);
      send_item(OP_RESERVED, 5'd31, 8'hFF, 9'd256);
      send_item(fm0_pkg::OP_TICK, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_TICK, 5'd31, 8'hFF, 9'd256);
      send_item(fm0_pkg::OP_WRITE, 5'd0, 8'hFF, 9'd0);
      send_item(fm0_pkg::OP_WRITE, 5'd31, 8'h00, 9'd256);
      send_item(fm0_pkg::OP_WRITE, 5'd1, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_WRITE, 5'd2, 8'hA5, 9'd0);
      send_item(fm0_pkg::OP_START, 5'd31, 8'hFF, 9'd256);
      send_item(fm0_pkg::OP_TICK, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_TICK, 5'd0, 8'h00, 9'd0);
      send_item(OP_RESERVED, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_TICK, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_START, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_TICK, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_TICK, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_START, 5'd0, 8'h00, 9'd1);
      send_item(fm0_pkg::OP_TICK, 5'd0, 8'h00, 9'd0);
      send_item(fm0_pkg::OP_WRITE, 5'd0, 8'h00, 9'd0);

      // Random part in phases, each under its own preamble pattern.
      base = sent_total;
      for (int p = 0; p < PHASES; p++) begin
         pattern = (p == 0) ? 18'h00000 : 18'($urandom_range(0, 18'h3FFFF));
         write_preamble(pattern);
         quiet_req <= (p >= 2);
         quiet_rsp <= (p == 2);
         first = 1'b1;
         do begin
            big   = ($urandom_range(0, 7) == 0);
            count = big ? $urandom_range(200, 256) : $urandom_range(0, 48);
            whole = big ? 1'b0 : ($urandom_range(0, 7) != 0);
            if (first && p == 0)
               run_frame(0, 1'b1, 1'b0);
            else if (first && p == 1)
               run_frame(256, 1'b0, 1'b0);
            else
               run_frame(count, whole, first && p == 2);
            first = 1'b0;
         end while (sent_total - base < (p + 1) * PHASE_ITEMS);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Sent %0d requests over %0d frames under %0d preamble patterns.",
               sent_total, frame_total, setting_total);
      $display("Checked %0d responses; %0d mismatches reported.", response_count, error_count);
      if (error_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timed out with %0d responses outstanding.", pending_count);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
